/* rtl/core/gbr_pkg.sv */
// shared types and constants of the rgb gaussian blur block
`timescale 1ns / 1ps

package gbr_pkg;

  localparam int unsigned CH_W   = 8;   // one color channel
  localparam int unsigned NUM_CH = 3;   // red, green, blue
  localparam int unsigned POS_W  = 11;  // column / row counters
  localparam int unsigned SIZE_W = 12;  // image width / height registers
  localparam int unsigned V5_W   = 12;  // 1-4-6-4-1 column sum, at most 16 * 255
  localparam int unsigned V3_W   = 10;  // 1-2-1 column sum, at most 4 * 255
  localparam int unsigned H5_W   = 16;  // full 5x5 sum, at most 256 * 255
  localparam int unsigned H3_W   = 12;  // full 3x3 sum, at most 16 * 255
  localparam int unsigned H5_SHIFT = 8; // divide by 256
  localparam int unsigned H3_SHIFT = 4; // divide by 16

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SIZE_W;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  localparam logic [POS_W-1:0]  POS_MAX     = 11'd2047;
  localparam logic [SIZE_W-1:0] WIDTH_RST   = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST  = 12'd480;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_MODE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_e;

  // channel 0 red, 1 green, 2 blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] px_t;
  typedef logic [NUM_CH-1:0][V5_W-1:0] v5_t;
  typedef logic [NUM_CH-1:0][V3_W-1:0] v3_t;

  typedef struct packed {
    logic              frame_end;
    logic [POS_W-1:0]  center_row;
    logic [POS_W-1:0]  center_col;
    logic [CH_W-1:0]   out_blue;
    logic [CH_W-1:0]   out_green;
    logic [CH_W-1:0]   out_red;
  } result_t;

endpackage

/* rtl/core/gaussian_blur_rgb.sv */
// top level of the rgb gaussian blur: line memory, column sums, result queue
`timescale 1ns / 1ps

// gaussian_blur_rgb
// pixels of a frame enter in raster order on the s_axis channel, one transfer
// per pixel, red in the low byte of tdata. for every pixel whose 3x3 or 5x5
// neighborhood lies wholly inside the frame one result leaves on m_axis:
// filtered red, green, blue and the centre column and row; tlast marks the
// last interior pixel of the frame. border pixels give no result.
// kernel_mode, image_width and image_height are set through the cfg write
// port (index 0, 1, 2) while the block is idle; other indexes are ignored.
// throughput: one pixel per cycle while the queue leaves s_axis_tready high;
// a result is offered on m_axis from the result queue. the pace is set by the line
// memory, one read and one write of a column entry per pixel; a column read
// that hits the entry still being written is forwarded.
// the result queue holds four entries; s_axis_tready drops when the queue
// and the pixels still in flight could fill it, so a stalled receiver only
// holds back the input, nothing is lost.
// reset clears counters, column sums, the queue and loads the register
// defaults (3x3, 640 x 480); the line memory is not cleared, rows are always
// written before a result depends on them.
module gaussian_blur_rgb #(
  parameter int unsigned MAX_WIDTH = 2048,
  parameter int unsigned LINE_ROWS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gbr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // pixel input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // in_red, in_green, in_blue
  // result output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [47:0]                      m_axis_tdata,  // out_red, out_green, out_blue,
                                                          // center_col, center_row, zero pad
  output logic                             m_axis_tlast   // frame_end
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CH = gbr_pkg::NUM_CH;

  // ---------------------------------------------------------------------------
  // configuration registers
  logic                            mode_q;
  logic [gbr_pkg::SIZE_W-1:0]      width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= gbr_pkg::WIDTH_RST;
      height_q <= gbr_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gbr_pkg::CFG_KERNEL_MODE:  mode_q   <= cfg_wdata_i[0];
        gbr_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        gbr_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: position counters, line memory read issue
  logic                          in_fire;
  logic [gbr_pkg::POS_W-1:0]     col_q, col_d, row_q, row_d;
  logic [gbr_pkg::SIZE_W-1:0]    col_inc, row_inc;
  logic                          last_col, last_row;
  logic                          in_range;
  logic [AW-1:0]                 rd_addr;
  logic [gbr_pkg::POS_W-1:0]     rad;
  logic                          emit;
  gbr_pkg::px_t                  in_px;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign in_px[0] = s_axis_tdata[7:0];
  assign in_px[1] = s_axis_tdata[15:8];
  assign in_px[2] = s_axis_tdata[23:16];

  always_comb begin
    col_inc  = {1'b0, col_q} + 12'd1;
    row_inc  = {1'b0, row_q} + 12'd1;
    last_col = (col_inc >= width_q) || (col_q == gbr_pkg::POS_MAX);
    last_row = (row_inc >= height_q) || (row_q == gbr_pkg::POS_MAX);
    col_d    = col_q;
    row_d    = row_q;
    if (in_fire) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[gbr_pkg::POS_W-1:0];
      end else begin
        col_d = col_inc[gbr_pkg::POS_W-1:0];
      end
    end
    rad      = mode_q ? 11'd2 : 11'd1;
    emit     = (col_q >= (rad << 1)) && (row_q >= (rad << 1));
    in_range = 32'(col_q) < MAX_WIDTH;
    rd_addr  = AW'(col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 registers: pixel, read data, forward path
  logic                          s1_valid_q;
  gbr_pkg::px_t                  s1_px_q;
  logic [gbr_pkg::POS_W-1:0]     s1_c_q;
  logic                          s1_inrange_q;
  logic                          s1_fwd_q;
  gbr_pkg::px_t [LINE_ROWS-1:0]  s1_fwd_data_q;
  logic                          s1_emit_q;
  logic [gbr_pkg::POS_W-1:0]     s1_ccol_q, s1_crow_q;
  logic                          s1_end_q;

  gbr_pkg::px_t [LINE_ROWS-1:0]  line_mem_q [MAX_WIDTH];
  gbr_pkg::px_t [LINE_ROWS-1:0]  rd_data_q;
  gbr_pkg::px_t [LINE_ROWS-1:0]  s1_lines;   // lines at this column, after forwarding
  gbr_pkg::px_t [LINE_ROWS-1:0]  s1_wdata;   // shifted lines written back
  logic                          s1_we;
  logic                          fwd_hit;

  // the entry written by stage 1 is the one read again when a row is one pixel long
  assign fwd_hit = s1_valid_q && s1_inrange_q && in_range && (s1_c_q == col_q);
  assign s1_we   = s1_valid_q && s1_inrange_q;

  always_comb begin
    s1_lines = s1_fwd_q ? s1_fwd_data_q : rd_data_q;
    if (!s1_inrange_q) begin
      s1_lines = '0;
    end
    for (int k = 0; k < LINE_ROWS; k++) begin
      if (k == 0) begin
        s1_wdata[k] = s1_px_q;
      end else begin
        s1_wdata[k] = s1_lines[k-1];
      end
    end
  end

  // line memory: one column entry per address, line k holds row (current - 1 - k)
  always_ff @(posedge clk_i) begin
    if (s1_we) begin
      line_mem_q[AW'(s1_c_q)] <= s1_wdata;
    end
    if (in_fire) begin
      rd_data_q <= line_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q       <= in_px;
      s1_c_q        <= col_q;
      s1_inrange_q  <= in_range;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_data_q <= s1_wdata;
      s1_emit_q     <= emit;
      s1_ccol_q     <= col_q - rad;
      s1_crow_q     <= row_q - rad;
      s1_end_q      <= last_col && last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 logic: vertical sums of the new column for both kernels
  gbr_pkg::px_t                  vcol [5];   // rows r-4 .. r
  gbr_pkg::v5_t                  v5_new;
  gbr_pkg::v3_t                  v3_new;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < LINE_ROWS) begin
        vcol[3-k] = s1_lines[k];
      end else begin
        vcol[3-k] = '0;
      end
    end
    vcol[4] = s1_px_q;
    for (int ch = 0; ch < CH; ch++) begin
      v5_new[ch] = 12'(vcol[0][ch]) + (12'(vcol[1][ch]) << 2)
                 + (12'(vcol[2][ch]) << 2) + (12'(vcol[2][ch]) << 1)
                 + (12'(vcol[3][ch]) << 2) + 12'(vcol[4][ch]);
      v3_new[ch] = 10'(vcol[2][ch]) + (10'(vcol[3][ch]) << 1) + 10'(vcol[4][ch]);
    end
  end

  // column sum windows, newest column at the highest index
  gbr_pkg::v5_t                  v5_q [5];
  gbr_pkg::v3_t                  v3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 5; j++) v5_q[j] <= '0;
      for (int j = 0; j < 3; j++) v3_q[j] <= '0;
    end else if (s1_valid_q) begin
      for (int j = 0; j < 4; j++) v5_q[j] <= v5_q[j+1];
      v5_q[4] <= v5_new;
      for (int j = 0; j < 2; j++) v3_q[j] <= v3_q[j+1];
      v3_q[2] <= v3_new;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: horizontal sums, result into the queue
  logic                          p_valid_q;
  logic                          p_emit_q;
  logic                          p_mode_q;
  logic [gbr_pkg::POS_W-1:0]     p_ccol_q, p_crow_q;
  logic                          p_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      p_emit_q <= s1_emit_q;
      p_mode_q <= mode_q;
      p_ccol_q <= s1_ccol_q;
      p_crow_q <= s1_crow_q;
      p_end_q  <= s1_end_q;
    end
  end

  logic [gbr_pkg::H5_W-1:0]      h5 [CH];
  logic [gbr_pkg::H3_W-1:0]      h3 [CH];
  gbr_pkg::px_t                  filt;
  gbr_pkg::result_t              res;

  always_comb begin
    for (int ch = 0; ch < CH; ch++) begin
      h5[ch] = 16'(v5_q[0][ch]) + (16'(v5_q[1][ch]) << 2)
             + (16'(v5_q[2][ch]) << 2) + (16'(v5_q[2][ch]) << 1)
             + (16'(v5_q[3][ch]) << 2) + 16'(v5_q[4][ch]);
      h3[ch] = 12'(v3_q[0][ch]) + (12'(v3_q[1][ch]) << 1) + 12'(v3_q[2][ch]);
      filt[ch] = p_mode_q ? h5[ch][gbr_pkg::H5_SHIFT +: gbr_pkg::CH_W]
                          : h3[ch][gbr_pkg::H3_SHIFT +: gbr_pkg::CH_W];
    end
    res.out_red    = filt[0];
    res.out_green  = filt[1];
    res.out_blue   = filt[2];
    res.center_col = p_ccol_q;
    res.center_row = p_crow_q;
    res.frame_end  = p_end_q;
  end

  // ---------------------------------------------------------------------------
  // result queue
  gbr_pkg::result_t              fifo_q [gbr_pkg::FIFO_DEPTH];
  logic [gbr_pkg::FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [gbr_pkg::FIFO_CW-1:0]   cnt_q, cnt_d;
  logic [gbr_pkg::FIFO_CW-1:0]   in_flight;
  logic                          push, pop;
  gbr_pkg::result_t              head;

  assign push = p_valid_q && p_emit_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  // reserve room for every pixel still in stage 1 or 2
  assign in_flight     = cnt_q + {2'b00, s1_valid_q} + {2'b00, p_valid_q};
  assign s_axis_tready = in_flight < 3'(gbr_pkg::FIFO_DEPTH);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 3'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tlast  = head.frame_end;
  assign m_axis_tdata  = {2'b00, head.center_row, head.center_col,
                          head.out_blue, head.out_green, head.out_red};

endmodule

/* tb/sv/tb.sv */
// self-checking testbench of the rgb gaussian blur, with its own pixel-level predictor
`timescale 1ns / 1ps

module tb;

  // run limits and timing knobs
  localparam int unsigned LIMIT_CYCLES  = 2_000_000;  // watchdog, several times the slowest run
  localparam int unsigned SETTLE_CYCLES = 16;         // quiet cycles after the last result
  localparam int unsigned HOLD_LEN      = 400;        // length of the receiver hold-off
  localparam int unsigned RANDOM_PIXELS = 300;

  // the one index the write port decodes to nothing
  localparam logic [gbr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // binomial weights, one axis
  localparam int unsigned W3 [3] = '{1, 2, 1};
  localparam int unsigned W5 [5] = '{1, 4, 6, 4, 1};

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port, idle from time zero
  logic                           cfg_we    = 1'b0;
  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [gbr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // pixel side, driven by the tb
  logic         tx_valid = 1'b0;
  gbr_pkg::px_t tx_data  = '0;  // red in [7:0], green in [15:8], blue in [23:16]
  logic         s_tready;

  // result side
  logic        rx_ready = 1'b0;
  logic        m_tvalid;
  logic [47:0] m_tdata;
  logic        m_tlast;

  gaussian_blur_rgb i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (tx_valid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (tx_data),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (rx_ready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: line memory, window, raster position and a copy of the
  // registers as the block should see them
  // ---------------------------------------------------------------------------
  gbr_pkg::px_t              line_mem [4][2048];  // line k holds row (current - 1 - k)
  gbr_pkg::px_t              win      [5][5];     // row 4 current, column 4 newest
  logic [gbr_pkg::POS_W-1:0]  col_pos    = '0;
  logic [gbr_pkg::POS_W-1:0]  row_pos    = '0;
  logic                       big_mode   = 1'b0;
  logic [gbr_pkg::SIZE_W-1:0] width_reg  = gbr_pkg::WIDTH_RST;
  logic [gbr_pkg::SIZE_W-1:0] height_reg = gbr_pkg::HEIGHT_RST;

  gbr_pkg::result_t blur_expect_q [$];  // filtered pixels not yet seen on m_axis
  gbr_pkg::px_t     pixel_q       [$];  // pixels waiting for the driver
  int unsigned pushed_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned error_cnt    = 0;
  int unsigned cycle_cnt    = 0;

  task automatic report_error(string msg);
    $display("ERROR @%0d: %s", cycle_cnt, msg);
    error_cnt++;
  endtask

  // weighted sum of one channel over the window, scaled down by the kernel total
  function automatic logic [gbr_pkg::CH_W-1:0] blur_channel(int unsigned ch, logic big);
    int unsigned acc;
    acc = 0;
    if (big) begin
      for (int y = 0; y < 5; y++)
        for (int x = 0; x < 5; x++)
          acc += win[y][x][ch] * W5[y] * W5[x];
      return gbr_pkg::CH_W'(acc >> gbr_pkg::H5_SHIFT);
    end
    // 3x3 uses the bottom-right corner of the window
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++)
        acc += win[y + 2][x + 2][ch] * W3[y] * W3[x];
    return gbr_pkg::CH_W'(acc >> gbr_pkg::H3_SHIFT);
  endfunction

  // one accepted pixel: update line memory and window, queue a result if the
  // centre is interior, then advance the raster position
  function automatic void blur_predict(gbr_pkg::px_t px);
    gbr_pkg::px_t     fresh [5];
    int unsigned      c, r, rad;
    logic             last_col, last_row;
    gbr_pkg::result_t res;
    c        = col_pos;
    r        = row_pos;
    rad      = big_mode ? 2 : 1;
    last_col = (c + 1 >= width_reg) || (col_pos == gbr_pkg::POS_MAX);
    last_row = (r + 1 >= height_reg) || (row_pos == gbr_pkg::POS_MAX);

    // new column, oldest row on top
    for (int k = 0; k < 4; k++) fresh[3 - k] = line_mem[k][c];
    fresh[4] = px;
    for (int k = 3; k > 0; k--) line_mem[k][c] = line_mem[k - 1][c];
    line_mem[0][c] = px;

    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 4; x++) win[y][x] = win[y][x + 1];
      win[y][4] = fresh[y];
    end

    if (c >= 2 * rad && r >= 2 * rad) begin
      res.out_red    = blur_channel(0, big_mode);
      res.out_green  = blur_channel(1, big_mode);
      res.out_blue   = blur_channel(2, big_mode);
      res.center_col = gbr_pkg::POS_W'(c - rad);
      res.center_row = gbr_pkg::POS_W'(r - rad);
      res.frame_end  = last_col && last_row;
      blur_expect_q.push_back(res);
    end

    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of random length with random gaps; valid holds until the
  // transfer, the predictor runs on the transfer
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tx_valid && s_tready) begin
        blur_predict(tx_data);
        accepted_cnt++;
      end
      if (!tx_valid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          tx_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          tx_data  <= pixel_q.pop_front();
          tx_valid <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            // new burst; a third of them follow on without a gap
            burst_left = $urandom_range(0, 31);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: one long hold-off in its own process, otherwise open and stalled runs
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  int unsigned rx_run  = 0;
  logic        rx_open = 1'b1;

  always @(posedge clk_i) begin
    if (rx_run == 0) begin
      rx_open = ($urandom_range(0, 3) != 0);
      rx_run  = rx_open ? $urandom_range(1, 40) : $urandom_range(1, 8);
    end else begin
      rx_run--;
    end
    rx_ready <= rst_ni && rx_open && (hold_left == 0);
  end

  // ---------------------------------------------------------------------------
  // monitor: every result transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got,
                             gbr_pkg::result_t ref_res);
    if (want != got)
      report_error($sformatf("%s at (%0d,%0d): expected %0d, got %0d", name,
                             ref_res.center_col, ref_res.center_row, want, got));
  endtask

  always @(posedge clk_i) begin : monitor
    gbr_pkg::result_t want, got;
    if (rst_ni && m_tvalid && rx_ready) begin
      if (blur_expect_q.size() == 0) begin
        report_error($sformatf("result with none expected, tdata %h", m_tdata));
      end else begin
        want = blur_expect_q.pop_front();
        // tdata packs the fields from red up; frame_end travels as tlast
        got  = gbr_pkg::result_t'({m_tlast, m_tdata[45:0]});
        check_field("out_red",    want.out_red,    got.out_red,    want);
        check_field("out_green",  want.out_green,  got.out_green,  want);
        check_field("out_blue",   want.out_blue,   got.out_blue,   want);
        check_field("center_col", want.center_col, got.center_col, want);
        check_field("center_row", want.center_row, got.center_row, want);
        check_field("frame_end",  want.frame_end,  got.frame_end,  want);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // every pixel transferred, every result out, then a few quiet cycles for
  // pixels still in the pipeline that give no result
  task automatic wait_idle();
    do @(posedge clk_i);
    while (accepted_cnt != pushed_cnt || blur_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [gbr_pkg::CFG_IDX_W-1:0] idx,
                           logic [gbr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    // registers keep only their own width; the spare index changes nothing
    case (idx)
      gbr_pkg::CFG_KERNEL_MODE:  big_mode   = val[0];
      gbr_pkg::CFG_IMAGE_WIDTH:  width_reg  = val;
      gbr_pkg::CFG_IMAGE_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_frame(logic mode, int unsigned w, int unsigned h);
    wait_idle();
    write_reg(gbr_pkg::CFG_KERNEL_MODE,  gbr_pkg::CFG_DATA_W'(mode));
    write_reg(gbr_pkg::CFG_IMAGE_WIDTH,  gbr_pkg::CFG_DATA_W'(w));
    write_reg(gbr_pkg::CFG_IMAGE_HEIGHT, gbr_pkg::CFG_DATA_W'(h));
  endtask

  // channel values lean toward the extremes
  function automatic logic [gbr_pkg::CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return gbr_pkg::CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixels(int unsigned n);
    gbr_pkg::px_t px;
    repeat (n) begin
      for (int ch = 0; ch < gbr_pkg::NUM_CH; ch++) px[ch] = rand_chan();
      pixel_q.push_back(px);
      pushed_cnt++;
    end
  endtask

  // one whole frame; optionally toggle the kernel in the middle of a row
  task automatic send_frame(int unsigned w, int unsigned h, logic flip);
    int unsigned first;
    first = flip ? (h / 2) * w + w / 2 : w * h;
    push_pixels(first);
    if (flip) begin
      wait_idle();
      write_reg(gbr_pkg::CFG_KERNEL_MODE, gbr_pkg::CFG_DATA_W'(!big_mode));
      push_pixels(w * h - first);
    end
  endtask

  initial begin : stimulus
    int unsigned  rand_done;
    int unsigned  w, h, frames;
    gbr_pkg::px_t px;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: one row of 640 and a few pixels of the next with 3x3,
    // then a 5 x 5 frame size; the next pixel closes row 1, so the centre
    // rows of the results show where the default width wrapped
    push_pixels(640 + 8);
    wait_idle();
    write_reg(gbr_pkg::CFG_IMAGE_WIDTH,  gbr_pkg::CFG_DATA_W'(5));
    write_reg(gbr_pkg::CFG_IMAGE_HEIGHT, gbr_pkg::CFG_DATA_W'(5));
    push_pixels(1 + 3 * 5);

    // smallest frame with 5x5, all channels at full scale: one centre, max sum
    set_frame(1'b1, 5, 5);
    repeat (25) begin
      pixel_q.push_back('1);
      pushed_cnt++;
    end

    // mode written with upper bits set keeps only bit 0; spare index ignored
    wait_idle();
    write_reg(gbr_pkg::CFG_KERNEL_MODE, 12'hFFE);
    write_reg(CFG_SPARE, 12'h005);
    repeat (25) begin
      for (int ch = 0; ch < gbr_pkg::NUM_CH; ch++) px[ch] = $urandom_range(0, 1) ? '1 : '0;
      pixel_q.push_back(px);
      pushed_cnt++;
    end

    // receiver holds off over a frame with many centres: queue fills, input stalls
    set_frame(1'b0, 16, 10);
    push_pixels(16 * 10);
    hold_req <= 1'b1;

    // random frames, mostly small, some with a kernel toggle mid-frame
    rand_done = 0;
    while (rand_done < RANDOM_PIXELS) begin
      w      = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 32) : $urandom_range(5, 16);
      h      = $urandom_range(5, 10);
      frames = (w > 16) ? 1 : $urandom_range(1, 2);
      set_frame(1'($urandom_range(0, 1)), w, h);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, gbr_pkg::CFG_DATA_W'($urandom));
      repeat (frames) send_frame(w, h, $urandom_range(0, 4) == 0);
      rand_done += w * h * frames;
    end

    wait_idle();
    if (error_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
